>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; each macro samples on clk_i and holds off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on every rising clock edge out of reset
`define FCHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that an expression never holds on a rising clock edge out of reset
`define FCHC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

>>> design/fchc_pkg.sv
// Shared types, constants and curve tables for the fan curve controller.
// No dependencies.
package fchc_pkg;

  localparam int unsigned IdxW       = 3;
  localparam int unsigned CountW     = 16;
  localparam int unsigned RpmW       = 22;
  localparam int unsigned StepCntW   = 5;
  localparam logic [IdxW-1:0] TopIndex = 3'd6;
  localparam logic [RpmW-1:0] RpmNumerator = 22'd2156220;
  localparam logic [StepCntW-1:0] DivSteps = 5'd22;

  // One input item: a sensor sample
  typedef struct packed {
    logic [7:0] core_temp;
    logic [7:0] gfx_temp;
    logic [7:0] duty_raw;
    logic [7:0] rpm_high;
    logic [7:0] rpm_low;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [6:0]      fan_level;
    logic            level_changed;
    logic [7:0]      pwm_value;
    logic [6:0]      reported_duty;
    logic [RpmW-1:0] fan_rpm;
    logic [7:0]      hottest_temp;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // Level in percent for each curve index
  function automatic logic [6:0] level_pct(input logic [IdxW-1:0] idx);
    logic [6:0] pct;
    case (idx)
      3'd0:    pct = 7'd10;
      3'd1:    pct = 7'd15;
      3'd2:    pct = 7'd25;
      3'd3:    pct = 7'd40;
      3'd4:    pct = 7'd60;
      3'd5:    pct = 7'd80;
      default: pct = 7'd100;
    endcase
    return pct;
  endfunction

  // PWM byte for each curve index, level * 255 / 100 truncated
  function automatic logic [7:0] level_pwm(input logic [IdxW-1:0] idx);
    logic [7:0] pwm;
    case (idx)
      3'd0:    pwm = 8'd25;
      3'd1:    pwm = 8'd38;
      3'd2:    pwm = 8'd63;
      3'd3:    pwm = 8'd102;
      3'd4:    pwm = 8'd153;
      3'd5:    pwm = 8'd204;
      default: pwm = 8'd255;
    endcase
    return pwm;
  endfunction

  // Temperature at or above which the level steps up
  function automatic logic [7:0] up_at(input logic [IdxW-1:0] idx);
    logic [7:0] t;
    case (idx)
      3'd0:    t = 8'd55;
      3'd1:    t = 8'd65;
      3'd2:    t = 8'd75;
      3'd3:    t = 8'd85;
      3'd4:    t = 8'd95;
      3'd5:    t = 8'd100;
      default: t = 8'd0;
    endcase
    return t;
  endfunction

  // Temperature at or below which the level steps down
  function automatic logic [7:0] down_at(input logic [IdxW-1:0] idx);
    logic [7:0] t;
    case (idx)
      3'd1:    t = 8'd45;
      3'd2:    t = 8'd55;
      3'd3:    t = 8'd65;
      3'd4:    t = 8'd75;
      3'd5:    t = 8'd85;
      3'd6:    t = 8'd95;
      default: t = 8'd0;
    endcase
    return t;
  endfunction

endpackage

>>> design/fan_curve_hysteresis_controller.sv
// Top level of the hysteresis fan curve controller.
// Depends on fchc_pkg, fchc_ctrl and fchc_dpath.
//
//   channel | signals                          | item
//   --------+----------------------------------+---------------------------
//   in      | in_valid_i, in_ready_o, in_data_i | one sensor sample
//   out     | out_valid_o, out_ready_i, out_data_o | level, PWM, duty, RPM
//
// An item is loaded, then the radix-2 restoring divider works out the RPM (one
// quotient bit a cycle), then the finished item moves into the output register.
// Reset clears the curve position, the announced level and all handshake state.
// A result waiting in the output register does not block the next sample; a
// finished item holds in the divider until the output register is free.
module fan_curve_hysteresis_controller import fchc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the item through the datapath
  fchc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Curve, conversions and divider
  fchc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> design/fchc_ctrl.sv
// Controller state machine: input handshake, divider sequencing, output register valid.
// Depends on fchc_pkg.
module fchc_ctrl import fchc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StDiv  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Output register can take a new item when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        if (!status_i.div_done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Track the output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/fchc_dpath.sv
// Datapath: fan curve state, per-sample conversions, radix-2 RPM divider, output register.
// Depends on fchc_pkg.
module fchc_dpath import fchc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_data_o
);

  // Curve state
  logic [IdxW-1:0] level_q, level_d;
  logic [IdxW-1:0] ann_q, ann_d;
  logic            ann_valid_q, ann_valid_d;

  // Per-item work registers
  logic [IdxW-1:0]   res_idx_q;
  logic              res_changed_q;
  logic [6:0]        res_duty_q;
  logic [7:0]        res_hot_q;
  logic [CountW-1:0] divisor_q;
  logic [CountW-1:0] rem_q;
  logic [RpmW-1:0]   quo_q;
  logic [StepCntW-1:0] step_q;
  out_item_t         out_q;

  logic [7:0]      hot;
  logic [IdxW-1:0] cur_idx;
  logic [IdxW-1:0] new_idx;
  logic            changed;
  logic [14:0]     duty_x100;
  logic [15:0]     duty_sum;
  logic [6:0]      duty_pct;
  logic [CountW:0] trial;
  logic            trial_ge;

  // Pick the hotter sensor and move one curve step at most
  always_comb begin
    hot     = (in_data_i.core_temp > in_data_i.gfx_temp) ? in_data_i.core_temp
                                                          : in_data_i.gfx_temp;
    cur_idx = (level_q > TopIndex) ? TopIndex : level_q;
    new_idx = cur_idx;
    if ((cur_idx < TopIndex) && (hot >= up_at(cur_idx))) begin
      new_idx = cur_idx + 3'd1;
    end else if ((cur_idx != 3'd0) && (hot <= down_at(cur_idx))) begin
      new_idx = cur_idx - 3'd1;
    end
    changed = !ann_valid_q || (ann_q != new_idx);
  end

  // Raw duty to percent: x / 255 as (x + 1 + (x >> 8)) >> 8, exact below 65535
  always_comb begin
    duty_x100 = {7'd0, in_data_i.duty_raw} * 15'd100;
    duty_sum  = {1'b0, duty_x100} + 16'd1 + {9'd0, duty_x100[14:8]};
    duty_pct  = duty_sum[14:8];
  end

  // Update the curve state on load
  always_comb begin
    level_d     = level_q;
    ann_d       = ann_q;
    ann_valid_d = ann_valid_q;
    if (cmd_i.load) begin
      level_d = new_idx;
      if (changed) begin
        ann_d       = new_idx;
        ann_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      ann_q       <= '0;
      ann_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      ann_q       <= ann_d;
      ann_valid_q <= ann_valid_d;
    end
  end

  // Shift-subtract trial for one quotient bit
  assign trial    = {rem_q, quo_q[RpmW-1]};
  assign trial_ge = trial >= {1'b0, divisor_q};

  // Step counter, cleared on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= DivSteps;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + 5'd1;
    end
  end

  assign status_o.div_done = (step_q == DivSteps);

  // Latch the sample results and run the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_idx_q     <= new_idx;
      res_changed_q <= changed;
      res_duty_q    <= duty_pct;
      res_hot_q     <= hot;
      divisor_q     <= {in_data_i.rpm_high, in_data_i.rpm_low};
      rem_q         <= '0;
      quo_q         <= RpmNumerator;
    end else if (cmd_i.step) begin
      rem_q <= trial_ge ? CountW'(trial - {1'b0, divisor_q}) : trial[CountW-1:0];
      quo_q <= {quo_q[RpmW-2:0], trial_ge};
    end
  end

  // Hand the finished item to the output register; zero count gives zero speed
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.fan_level     <= level_pct(res_idx_q);
      out_q.level_changed <= res_changed_q;
      out_q.pwm_value     <= level_pwm(res_idx_q);
      out_q.reported_duty <= res_duty_q;
      out_q.fan_rpm       <= (divisor_q == '0) ? '0 : quo_q;
      out_q.hottest_temp  <= res_hot_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> design/fchc_checker.sv
// Port-level checks for the fan curve controller, bound to the top level.
// Depends on fchc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fchc_checker import fchc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // Hold a stalled result item
  `FCHC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result item dropped or changed while stalled")

  // Go busy after taking a sample
  `FCHC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "input ready right after an accept")

  // Produce no result in the cycle straight after an accept
  `FCHC_ASSERT(a_no_early_result, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result appeared too early")

  // Free the input side as each new result appears
  `FCHC_ASSERT_NEVER(a_rise_ready, $rose(out_valid_o) && !in_ready_o, "new result without input ready")

endmodule

bind fan_curve_hysteresis_controller fchc_checker u_fchc_checker (.*);
